FILE: rtl/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define TCLC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define TCLC_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/tclc_pkg.sv
// Types, codes and the format block ROM of the texture copy layout calculator.
package tclc_pkg;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FMT   = 3'd1,
        ST_ZERO  = 3'd2,
        ST_PITCH = 3'd3,
        ST_RPI   = 3'd4,
        ST_OVF   = 3'd5
    } status_t;

    localparam logic [1:0] ASP_ALL     = 2'd0;
    localparam logic [1:0] ASP_DEPTH   = 2'd1;
    localparam logic [1:0] ASP_STENCIL = 2'd2;
    localparam logic [1:0] ASP_WHOLE   = 2'd3;

    localparam logic [6:0] FMT_LAST    = 7'd100;
    localparam logic [6:0] FMT_D16     = 7'd96;
    localparam logic [6:0] FMT_S8      = 7'd97;
    localparam logic [6:0] FMT_D24S8   = 7'd98;
    localparam logic [6:0] FMT_D32     = 7'd99;
    localparam logic [6:0] FMT_D32S8   = 7'd100;

    // bytes per block as log2, block width and height
    typedef struct packed {
        logic       ok;
        logic [2:0] bytes_lg;
        logic [3:0] bw;
        logic [3:0] bh;
    } lay_t;

    function automatic lay_t tclc_rom(input logic [6:0] fmt);
        lay_t r;
        r.ok = 1'b1;
        r.bw = 4'd1;
        r.bh = 4'd1;
        r.bytes_lg = 3'd0;
        case (fmt) inside
            [7'd1:7'd4]:                          r.bytes_lg = 3'd0;
            [7'd5:7'd13], 7'd96:                  r.bytes_lg = 3'd1;
            [7'd14:7'd32], 7'd97:                 r.bytes_lg = 3'd0;
            [7'd33:7'd40], 7'd100:                r.bytes_lg = 3'd3;
            [7'd41:7'd43]:                        r.bytes_lg = 3'd4;
            7'd98, 7'd99:                         r.bytes_lg = 3'd2;
            [7'd44:7'd45], [7'd50:7'd51], [7'd58:7'd59], [7'd64:7'd67]:
            begin
                r.bytes_lg = 3'd3;
                r.bw = 4'd4;
                r.bh = 4'd4;
            end
            [7'd46:7'd49], [7'd52:7'd57], [7'd60:7'd63], [7'd68:7'd69]:
            begin
                r.bytes_lg = 3'd4;
                r.bw = 4'd4;
                r.bh = 4'd4;
            end
            default:
            begin
                r.bytes_lg = 3'd4;
                r.ok = 1'b0;
            end
        endcase
        // texel formats 14..32 are 4 bytes
        if (fmt >= 7'd14 && fmt <= 7'd32)
        begin
            r.bytes_lg = 3'd2;
        end
        // S8 is 1 byte
        if (fmt == FMT_S8)
        begin
            r.bytes_lg = 3'd0;
        end
        if (fmt >= 7'd70 && fmt <= 7'd95)
        begin
            r.ok = 1'b1;
            r.bytes_lg = 3'd4;
            case (fmt) inside
                [7'd70:7'd71]: begin r.bw = 4'd5;  r.bh = 4'd4;  end
                [7'd72:7'd73]: begin r.bw = 4'd5;  r.bh = 4'd5;  end
                [7'd74:7'd75]: begin r.bw = 4'd6;  r.bh = 4'd5;  end
                [7'd76:7'd77]: begin r.bw = 4'd6;  r.bh = 4'd6;  end
                [7'd78:7'd79]: begin r.bw = 4'd8;  r.bh = 4'd5;  end
                [7'd80:7'd81]: begin r.bw = 4'd8;  r.bh = 4'd6;  end
                [7'd82:7'd83]: begin r.bw = 4'd8;  r.bh = 4'd8;  end
                [7'd84:7'd85]: begin r.bw = 4'd10; r.bh = 4'd5;  end
                [7'd86:7'd87]: begin r.bw = 4'd10; r.bh = 4'd6;  end
                [7'd88:7'd89]: begin r.bw = 4'd10; r.bh = 4'd8;  end
                [7'd90:7'd91]: begin r.bw = 4'd10; r.bh = 4'd10; end
                [7'd92:7'd93]: begin r.bw = 4'd12; r.bh = 4'd10; end
                default:       begin r.bw = 4'd12; r.bh = 4'd12; end
            endcase
        end
        return r;
    endfunction

    function automatic lay_t tclc_layout(input logic [6:0] fmt, input logic [1:0] asp);
        lay_t       r;
        logic       ok;
        logic [1:0] res;
        r = tclc_rom(fmt);
        ok = 1'b1;
        res = ASP_ALL;
        if (asp != ASP_WHOLE)
        begin
            case (fmt)
                FMT_D16, FMT_D32:
                begin
                    ok = (asp != ASP_STENCIL);
                    res = ASP_DEPTH;
                end
                FMT_S8:
                begin
                    ok = (asp != ASP_DEPTH);
                    res = ASP_STENCIL;
                end
                FMT_D24S8, FMT_D32S8:
                begin
                    ok = (asp != ASP_ALL);
                    res = asp;
                end
                default:
                begin
                    ok = (asp == ASP_ALL);
                    res = ASP_ALL;
                end
            endcase
            if (res == ASP_STENCIL)
            begin
                r.bytes_lg = 3'd0;
                r.bw = 4'd1;
                r.bh = 4'd1;
            end
            else if (res == ASP_DEPTH)
            begin
                r.bytes_lg = (fmt == FMT_D16) ? 3'd1 : 3'd2;
                r.bw = 4'd1;
                r.bh = 4'd1;
            end
        end
        r.ok = r.ok && ok && (fmt >= 7'd1) && (fmt <= FMT_LAST);
        return r;
    endfunction

endpackage

FILE: rtl/tclc_if.sv
// Request and response channel interfaces.
interface tclc_req_if;
    logic        valid;
    logic        ready;
    logic [6:0]  format_code;
    logic [1:0]  aspect;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] depth;
    logic [31:0] layer_count;
    logic [31:0] row_pitch;
    logic [31:0] rows_per_image;

    modport source (output valid, format_code, aspect, width, height, depth, layer_count,
                    row_pitch, rows_per_image, input ready);
    modport sink (input valid, format_code, aspect, width, height, depth, layer_count,
                  row_pitch, rows_per_image, output ready);
endinterface

interface tclc_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] bytes_per_image;
    logic [63:0] required_bytes;
    logic [31:0] last_row_bytes;
    logic [31:0] block_row_count;

    modport source (output valid, status, bytes_per_image, required_bytes, last_row_bytes,
                    block_row_count, input ready);
    modport sink (input valid, status, bytes_per_image, required_bytes, last_row_bytes,
                  block_row_count, output ready);
endinterface

FILE: rtl/tclc_blkdiv.sv
// Division by a block dimension (1,4,5,6,8,10,12) by shift or reciprocal multiply, one register stage.
module tclc_blkdiv (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] x,
    input  logic [3:0]  b,
    output logic [31:0] q
);
    logic [31:0] s;
    logic [31:0] k;
    logic [63:0] prod_next;
    logic [63:0] prod_reg;
    logic [31:0] x_reg;
    logic [3:0]  b_reg;

    always_comb
    begin
        case (b) inside
            4'd6, 4'd10: s = x >> 1;
            4'd12:       s = x >> 2;
            default:     s = x;
        endcase
        k = (b == 4'd5 || b == 4'd10) ? 32'hCCCC_CCCD : 32'hAAAA_AAAB;
        prod_next = {32'd0, s} * {32'd0, k};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            x_reg <= x;
            b_reg <= b;
        end
    end

    always_comb
    begin
        case (b_reg) inside
            4'd4:         q = x_reg >> 2;
            4'd8:         q = x_reg >> 3;
            4'd5, 4'd10:  q = {2'b00, prod_reg[63:34]};
            4'd6, 4'd12:  q = {1'b0, prod_reg[63:33]};
            default:      q = x_reg;
        endcase
    end
endmodule

FILE: rtl/texture_copy_layout_calc.sv
// Top level of the texture copy buffer layout calculator.
// Checks one texture/buffer copy request and returns its buffer layout.
// req: format code, aspect and copy extent; rsp: status, bytes per image,
// required bytes, last row bytes and block row count. Fields other than
// status read zero when status is not ok.
// Accepts one req beat per cycle unless every stage holds a beat and rsp
// stalls; seven register stages, each with its own valid bit, and the
// 64x64 overflow product split into four 32x32 partial products.
// Stages: format decode, block division multiply, quotient select and
// pitch checks, size products, partial products, product sum, final add.
// A stall on rsp holds the last stage; earlier stages keep filling empty
// slots, and req.ready drops only once every stage holds a beat.
// Reset clears all valid bits; no beat is lost or repeated across a stall.
module texture_copy_layout_calc (
    input logic        clk,
    input logic        rst_n,
    tclc_req_if.sink   req,
    tclc_rsp_if.source rsp
);
    import tclc_pkg::*;
    `include "assert_macros.svh"

    logic en1, en2, en3, en4, en5, en6, en7;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;

    assign en7 = !v7_reg || rsp.ready;
    assign en6 = !v6_reg || en7;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign req.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= req.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
            if (en7) v7_reg <= v6_reg;
        end
    end

    // stage 1: layout decode, early checks
    lay_t        lay_next;
    status_t     err1_next;
    lay_t        lay1_reg;
    status_t     err1_reg;
    logic [31:0] wm1_reg, hm1_reg, h1_reg, d1_reg, l1_reg, p1_reg, rpi1_reg;

    always_comb
    begin
        lay_next = tclc_layout(req.format_code, req.aspect);
        if (!lay_next.ok)
            err1_next = ST_FMT;
        else if (req.width == 32'd0 || req.height == 32'd0 || req.depth == 32'd0
                 || req.layer_count == 32'd0)
            err1_next = ST_ZERO;
        else if (req.row_pitch == 32'd0)
            err1_next = ST_PITCH;
        else
            err1_next = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            lay1_reg <= lay_next;
            err1_reg <= err1_next;
            wm1_reg <= req.width - 32'd1;
            hm1_reg <= req.height - 32'd1;
            h1_reg <= req.height;
            d1_reg <= req.depth;
            l1_reg <= req.layer_count;
            p1_reg <= req.row_pitch;
            rpi1_reg <= req.rows_per_image;
        end
    end

    // stage 2: reciprocal multiplies
    logic [31:0] qw, qh, qr;
    lay_t        lay2_reg;
    status_t     err2_reg;
    logic [31:0] h2_reg, d2_reg, l2_reg, p2_reg, rpi2_reg;

    tclc_blkdiv u_div_w (.clk(clk), .en(en2), .x(wm1_reg), .b(lay1_reg.bw), .q(qw));
    tclc_blkdiv u_div_h (.clk(clk), .en(en2), .x(hm1_reg), .b(lay1_reg.bh), .q(qh));
    tclc_blkdiv u_div_r (.clk(clk), .en(en2), .x(rpi1_reg), .b(lay1_reg.bh), .q(qr));

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            lay2_reg <= lay1_reg;
            err2_reg <= err1_reg;
            h2_reg <= h1_reg;
            d2_reg <= d1_reg;
            l2_reg <= l1_reg;
            p2_reg <= p1_reg;
            rpi2_reg <= rpi1_reg;
        end
    end

    // stage 3: block counts, last-row overflow, pitch and rows-per-image checks
    logic [31:0] rb, brows_next, img_next;
    logic [35:0] last36;
    logic [35:0] rpi_back;
    logic [31:0] mask;
    status_t     err3_next;
    status_t     err3_reg;
    logic [31:0] last3_reg, brows3_reg, img3_reg, d3_reg, l3_reg, p3_reg;

    always_comb
    begin
        rb = qw + 32'd1;
        brows_next = qh + 32'd1;
        last36 = {4'd0, rb} << lay2_reg.bytes_lg;
        mask = ~(32'hFFFF_FFFF << lay2_reg.bytes_lg);
        rpi_back = {4'd0, qr} * {32'd0, lay2_reg.bh};
        img_next = (rpi2_reg == 32'd0) ? brows_next : qr;
        err3_next = err2_reg;
        if (err2_reg == ST_OK)
        begin
            if (last36[35:32] != 4'd0)
                err3_next = ST_OVF;
            else if (p2_reg < last36[31:0] || (p2_reg & mask) != 32'd0)
                err3_next = ST_PITCH;
            else if (rpi2_reg != 32'd0 && (rpi2_reg < h2_reg || rpi_back[31:0] != rpi2_reg))
                err3_next = ST_RPI;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            err3_reg <= err3_next;
            last3_reg <= last36[31:0];
            brows3_reg <= brows_next;
            img3_reg <= img_next;
            d3_reg <= d2_reg;
            l3_reg <= l2_reg;
            p3_reg <= p2_reg;
        end
    end

    // stage 4: size products
    status_t     err4_reg;
    logic [63:0] bpi4_reg, images4_reg, rowpart4_reg;
    logic [31:0] last4_reg, brows4_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            err4_reg <= err3_reg;
            bpi4_reg <= {32'd0, p3_reg} * {32'd0, img3_reg};
            images4_reg <= {32'd0, d3_reg} * {32'd0, l3_reg};
            rowpart4_reg <= {32'd0, brows3_reg - 32'd1} * {32'd0, p3_reg};
            last4_reg <= last3_reg;
            brows4_reg <= brows3_reg;
        end
    end

    // stage 5: partial products of bpi * (images - 1), row part plus last row bytes
    logic [63:0] im1;
    status_t     err5_reg;
    logic [63:0] pp00_reg, pp01_reg, pp10_reg, pp11_reg, req5_reg, bpi5_reg;
    logic [31:0] last5_reg, brows5_reg;

    assign im1 = images4_reg - 64'd1;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            err5_reg <= err4_reg;
            pp00_reg <= {32'd0, bpi4_reg[31:0]} * {32'd0, im1[31:0]};
            pp01_reg <= {32'd0, bpi4_reg[31:0]} * {32'd0, im1[63:32]};
            pp10_reg <= {32'd0, bpi4_reg[63:32]} * {32'd0, im1[31:0]};
            pp11_reg <= {32'd0, bpi4_reg[63:32]} * {32'd0, im1[63:32]};
            req5_reg <= rowpart4_reg + {32'd0, last4_reg};
            bpi5_reg <= bpi4_reg;
            last5_reg <= last4_reg;
            brows5_reg <= brows4_reg;
        end
    end

    // stage 6: full product
    logic [127:0] prod128;
    status_t      err6_reg;
    logic         hi6_reg;
    logic [63:0]  prev6_reg, req6_reg, bpi6_reg;
    logic [31:0]  last6_reg, brows6_reg;

    assign prod128 = {64'd0, pp00_reg} + {32'd0, pp01_reg, 32'd0} + {32'd0, pp10_reg, 32'd0}
                   + {pp11_reg, 64'd0};

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            err6_reg <= err5_reg;
            hi6_reg <= (prod128[127:64] != 64'd0);
            prev6_reg <= prod128[63:0];
            req6_reg <= req5_reg;
            bpi6_reg <= bpi5_reg;
            last6_reg <= last5_reg;
            brows6_reg <= brows5_reg;
        end
    end

    // stage 7: final sum and result register
    logic [64:0] total;
    status_t     st_next;
    status_t     st7_reg;
    logic [63:0] bpi7_reg, req7_reg;
    logic [31:0] last7_reg, brows7_reg;

    always_comb
    begin
        total = {1'b0, req6_reg} + {1'b0, prev6_reg};
        st_next = err6_reg;
        if (err6_reg == ST_OK && (hi6_reg || total[64]))
            st_next = ST_OVF;
    end

    always_ff @(posedge clk)
    begin
        if (en7)
        begin
            st7_reg <= st_next;
            bpi7_reg <= (st_next == ST_OK) ? bpi6_reg : 64'd0;
            req7_reg <= (st_next == ST_OK) ? total[63:0] : 64'd0;
            last7_reg <= (st_next == ST_OK) ? last6_reg : 32'd0;
            brows7_reg <= (st_next == ST_OK) ? brows6_reg : 32'd0;
        end
    end

    assign rsp.valid = v7_reg;
    assign rsp.status = st7_reg;
    assign rsp.bytes_per_image = bpi7_reg;
    assign rsp.required_bytes = req7_reg;
    assign rsp.last_row_bytes = last7_reg;
    assign rsp.block_row_count = brows7_reg;

    `TCLC_ASSERT(a_err_zero, clk, rst_n, (rsp.valid && rsp.status != ST_OK) |-> (rsp.bytes_per_image == 64'd0 && rsp.required_bytes == 64'd0 && rsp.last_row_bytes == 32'd0 && rsp.block_row_count == 32'd0), "error result carries nonzero fields")
    `TCLC_ASSERT(a_ok_nonzero, clk, rst_n, (rsp.valid && rsp.status == ST_OK) |-> (rsp.block_row_count != 32'd0 && rsp.last_row_bytes != 32'd0 && rsp.required_bytes >= {32'd0, rsp.last_row_bytes}), "ok result with empty layout")
    `TCLC_NEVER(a_full_only, clk, rst_n, !req.ready && !(v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && v6_reg && v7_reg), "request stalled with a free stage")
    `TCLC_ASSERT(a_hold_out, clk, rst_n, (v7_reg && !rsp.ready) |=> (v7_reg && $stable(st7_reg)), "stalled beat dropped")
endmodule

FILE: bench/tclc_layout_checker.sv
// Checker: predicts each copy layout result from the request beats and compares the response beats.
module tclc_layout_checker (
    input  logic        clk,
    input  logic        rst_n,
    tclc_req_if.sink    req_mon,
    tclc_rsp_if.sink    rsp_mon,
    output int          fail_count,
    output int          pending
);
    import tclc_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] bpi;
        logic [63:0] req_bytes;
        logic [31:0] last;
        logic [31:0] brows;
    } layout_t;

    layout_t layout_q[$];

    // bytes, block width, block height from the format table
    function automatic void fmt_block(input logic [6:0] f, output int unsigned by,
                                      output int unsigned bw, output int unsigned bh);
        bw = 1;
        bh = 1;
        if (f <= 4) by = 1;
        else if (f <= 13) by = 2;
        else if (f <= 32) by = 4;
        else if (f <= 40) by = 8;
        else if (f <= 43) by = 16;
        else if (f <= 69)
        begin
            bw = 4;
            bh = 4;
            if (f == 44 || f == 45 || f == 50 || f == 51 || f == 58 || f == 59 ||
                (f >= 64 && f <= 67))
                by = 8;
            else
                by = 16;
        end
        else if (f <= 95)
        begin
            by = 16;
            case ((f - 70) / 2)
                0: begin bw = 5;  bh = 4;  end
                1: begin bw = 5;  bh = 5;  end
                2: begin bw = 6;  bh = 5;  end
                3: begin bw = 6;  bh = 6;  end
                4: begin bw = 8;  bh = 5;  end
                5: begin bw = 8;  bh = 6;  end
                6: begin bw = 8;  bh = 8;  end
                7: begin bw = 10; bh = 5;  end
                8: begin bw = 10; bh = 6;  end
                9: begin bw = 10; bh = 8;  end
                10: begin bw = 10; bh = 10; end
                11: begin bw = 12; bh = 10; end
                default: begin bw = 12; bh = 12; end
            endcase
        end
        else if (f == FMT_D16) by = 2;
        else if (f == FMT_S8) by = 1;
        else if (f == FMT_D24S8 || f == FMT_D32) by = 4;
        else by = 8;
    endfunction

    function automatic layout_t calc_layout(input logic [6:0] f, input logic [1:0] a,
        input logic [31:0] w, input logic [31:0] h, input logic [31:0] d,
        input logic [31:0] l, input logic [31:0] pitch, input logic [31:0] rpi);
        layout_t r;
        int unsigned by, bw, bh;
        logic [1:0] res;
        logic ok;
        logic [31:0] rb, br;
        logic [63:0] last, img_rows, bpi, images, reqb, prev;
        logic [127:0] wide;
        r = '0;
        if (f < 1 || f > FMT_LAST)
        begin
            r.status = ST_FMT;
            return r;
        end
        fmt_block(f, by, bw, bh);
        ok = 1'b1;
        res = ASP_ALL;
        if (a != ASP_WHOLE)
        begin
            if (f == FMT_D16 || f == FMT_D32)
            begin
                ok = (a != ASP_STENCIL);
                res = ASP_DEPTH;
            end
            else if (f == FMT_S8)
            begin
                ok = (a != ASP_DEPTH);
                res = ASP_STENCIL;
            end
            else if (f == FMT_D24S8 || f == FMT_D32S8)
            begin
                ok = (a != ASP_ALL);
                res = a;
            end
            else
                ok = (a == ASP_ALL);
            if (res == ASP_STENCIL)
            begin
                by = 1; bw = 1; bh = 1;
            end
            else if (res == ASP_DEPTH)
            begin
                by = (f == FMT_D16) ? 2 : 4; bw = 1; bh = 1;
            end
        end
        if (!ok)
        begin
            r.status = ST_FMT;
            return r;
        end
        if (w == 0 || h == 0 || d == 0 || l == 0)
        begin
            r.status = ST_ZERO;
            return r;
        end
        if (pitch == 0)
        begin
            r.status = ST_PITCH;
            return r;
        end
        rb = 1 + (w - 1) / bw;
        br = 1 + (h - 1) / bh;
        last = 64'(rb) * by;
        if (last > 64'hFFFF_FFFF)
        begin
            r.status = ST_OVF;
            return r;
        end
        if (64'(pitch) < last || pitch % by != 0)
        begin
            r.status = ST_PITCH;
            return r;
        end
        if (rpi != 0)
        begin
            if (rpi < h || rpi % bh != 0)
            begin
                r.status = ST_RPI;
                return r;
            end
            img_rows = rpi / bh;
        end
        else
            img_rows = br;
        bpi = 64'(pitch) * img_rows;
        images = 64'(d) * 64'(l);
        reqb = last + 64'(br - 1) * 64'(pitch);
        if (images > 1)
        begin
            wide = 128'(bpi) * 128'(images - 1);
            if (wide[127:64] != 0)
            begin
                r.status = ST_OVF;
                return r;
            end
            prev = wide[63:0];
            if (reqb > ~prev)
            begin
                r.status = ST_OVF;
                return r;
            end
            reqb += prev;
        end
        r.status = ST_OK;
        r.bpi = bpi;
        r.req_bytes = reqb;
        r.last = last[31:0];
        r.brows = br;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        layout_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (req_mon.valid && req_mon.ready)
                layout_q.push_back(calc_layout(req_mon.format_code, req_mon.aspect,
                    req_mon.width, req_mon.height, req_mon.depth, req_mon.layer_count,
                    req_mon.row_pitch, req_mon.rows_per_image));
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                if (layout_q.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = layout_q.pop_front();
                    if (rsp_mon.status !== e.status ||
                        rsp_mon.bytes_per_image !== e.bpi ||
                        rsp_mon.required_bytes !== e.req_bytes ||
                        rsp_mon.last_row_bytes !== e.last ||
                        rsp_mon.block_row_count !== e.brows)
                        fail_count <= fail_count + 1;
                    if (rsp_mon.status !== e.status)
                        $error("status expected %0d actual %0d", e.status, rsp_mon.status);
                    if (rsp_mon.bytes_per_image !== e.bpi)
                        $error("bytes_per_image expected %0h actual %0h", e.bpi,
                               rsp_mon.bytes_per_image);
                    if (rsp_mon.required_bytes !== e.req_bytes)
                        $error("required_bytes expected %0h actual %0h", e.req_bytes,
                               rsp_mon.required_bytes);
                    if (rsp_mon.last_row_bytes !== e.last)
                        $error("last_row_bytes expected %0h actual %0h", e.last,
                               rsp_mon.last_row_bytes);
                    if (rsp_mon.block_row_count !== e.brows)
                        $error("block_row_count expected %0h actual %0h", e.brows,
                               rsp_mon.block_row_count);
                end
            end
            pending <= layout_q.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
// Testbench top: drives copy requests and response backpressure, reports the verdict.
module tb_top;
    import tclc_pkg::*;

    logic clk;
    logic rst_n;
    logic hold_go;
    int   fails;
    int   pending;
    int   send_idle;
    int   recv_idle;
    int   hold_cycles;

    tclc_req_if req ();
    tclc_rsp_if rsp ();

    texture_copy_layout_calc dut (.clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source));

    tclc_layout_checker chk (.clk(clk), .rst_n(rst_n), .req_mon(req.sink), .rsp_mon(rsp.sink),
                             .fail_count(fails), .pending(pending));

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("texture_copy_layout_calc verification failed");
        $finish;
    end

    // receiver: random stalls plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 0;
            rsp.ready <= 1'b0;
        end
        else if (hold_go)
        begin
            hold_cycles <= 200;
            rsp.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic logic [31:0] rand_val();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            3: return 32'(1) << $urandom_range(31);
            default: return $urandom_range(64, 1);
        endcase
    endfunction

    task automatic send_beat(input logic [6:0] f, input logic [1:0] a, input logic [31:0] w,
        input logic [31:0] h, input logic [31:0] d, input logic [31:0] l,
        input logic [31:0] p, input logic [31:0] rpi);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.format_code <= f;
        req.aspect <= a;
        req.width <= w;
        req.height <= h;
        req.depth <= d;
        req.layer_count <= l;
        req.row_pitch <= p;
        req.rows_per_image <= rpi;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // mostly well-formed requests: pitch a multiple of 16, rows per image zero or a multiple of 12 for block formats
    task automatic send_random();
        logic [6:0] f;
        logic [1:0] a;
        logic [31:0] w, h, d, l, p, rpi;
        int unsigned bh;
        f = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(100, 1));
        a = ($urandom_range(3) == 0) ? 2'($urandom) : (f >= 96 ? 2'($urandom_range(2, 1)) :
            ASP_ALL);
        if ($urandom_range(4) == 0)
        begin
            w = rand_val(); h = rand_val(); d = rand_val(); l = rand_val();
            p = rand_val(); rpi = rand_val();
        end
        else
        begin
            w = $urandom_range(300, 1);
            h = $urandom_range(300, 1);
            d = $urandom_range(4, 1);
            l = ($urandom_range(9) == 0) ? $urandom : $urandom_range(4, 1);
            p = 32'($urandom_range(5000, 1)) * 16;
            if ($urandom_range(9) == 0) p = p << $urandom_range(16);
            bh = (f >= 44 && f <= 95 && a != ASP_DEPTH && a != ASP_STENCIL) ? 12 : 1;
            rpi = ($urandom_range(1) == 0) ? 32'd0 : (h + $urandom_range(30)) * bh;
        end
        send_beat(f, a, w, h, d, l, p, rpi);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        hold_go = 1'b0;
        req.valid = 1'b0;
        req.format_code = '0;
        req.aspect = '0;
        req.width = '0;
        req.height = '0;
        req.depth = '0;
        req.layer_count = '0;
        req.row_pitch = '0;
        req.rows_per_image = '0;
        send_idle = 0;
        recv_idle = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: invalid codes, aspects, zero extents, pitch, rows-per-image and overflow corners
        send_beat(7'd0, ASP_ALL, 1, 1, 1, 1, 4, 0);
        send_beat(7'd127, ASP_WHOLE, 1, 1, 1, 1, 4, 0);
        send_beat(7'd101, ASP_ALL, 1, 1, 1, 1, 4, 0);
        send_beat(7'd1, ASP_ALL, 1, 1, 1, 1, 1, 0);
        send_beat(7'd1, ASP_DEPTH, 1, 1, 1, 1, 1, 0);
        send_beat(FMT_D16, ASP_STENCIL, 4, 4, 1, 1, 64, 0);
        send_beat(FMT_D16, ASP_DEPTH, 4, 4, 1, 1, 64, 0);
        send_beat(FMT_S8, ASP_DEPTH, 4, 4, 1, 1, 64, 0);
        send_beat(FMT_S8, ASP_STENCIL, 4, 4, 1, 1, 64, 0);
        send_beat(FMT_D24S8, ASP_ALL, 4, 4, 1, 1, 64, 0);
        send_beat(FMT_D24S8, ASP_STENCIL, 4, 4, 1, 1, 64, 0);
        send_beat(FMT_D32S8, ASP_DEPTH, 4, 4, 2, 2, 64, 8);
        send_beat(FMT_D32S8, ASP_WHOLE, 4, 4, 2, 2, 64, 8);
        send_beat(7'd14, ASP_ALL, 0, 1, 1, 1, 4, 0);
        send_beat(7'd14, ASP_ALL, 1, 1, 1, 0, 4, 0);
        send_beat(7'd14, ASP_ALL, 1, 1, 1, 1, 0, 0);
        send_beat(7'd41, ASP_ALL, 32'hFFFF_FFFF, 1, 1, 1, 32'hFFFF_FFF0, 0);
        send_beat(7'd14, ASP_ALL, 8, 1, 1, 1, 30, 0);
        send_beat(7'd14, ASP_ALL, 8, 1, 1, 1, 34, 0);
        send_beat(7'd95, ASP_ALL, 24, 24, 1, 1, 32, 20);
        send_beat(7'd95, ASP_ALL, 24, 24, 1, 1, 32, 24);
        send_beat(7'd43, ASP_ALL, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFF0, 0);
        send_beat(7'd1, ASP_ALL, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_beat(7'd100, ASP_WHOLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // long receiver hold-off while the sender keeps offering
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        repeat (40) send_random();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 25 : (ph == 1) ? 70 : 0;
            recv_idle = (ph == 0) ? 70 : (ph == 1) ? 25 : 0;
            repeat (600) send_random();
        end
        req.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("texture_copy_layout_calc verification clean");
        else
            $display("texture_copy_layout_calc verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tclc_pkg.sv
rtl/tclc_if.sv
rtl/tclc_blkdiv.sv
rtl/texture_copy_layout_calc.sv
bench/tclc_layout_checker.sv
bench/tb_top.sv
